[hw/rtl/prc_pkg.sv]
// ----------------------------------------------------------------------------
// prc_pkg
// Types, constants and helpers shared by the polar/rectangular converter.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Conversion selects.
  localparam logic FUNC_P2R = 1'b0;
  localparam logic FUNC_R2P = 1'b1;

  // Datapath formats: operands carry 14 guard bits, angles are 2^-20 degree.
  localparam int unsigned GUARD_BITS = 14;
  localparam int unsigned ANG_SHIFT  = 13;
  localparam int unsigned XY_W       = 33;
  localparam int unsigned Z_W        = 29;
  localparam int unsigned TABLE_LEN  = 24;

  // Angles in 1/128 degree.
  localparam logic signed [16:0] FULL_TURN    = 17'sd46080;
  localparam logic signed [16:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;

  // Result saturation limits.
  localparam logic signed [19:0] RES_LIMIT = 20'sd46341;
  localparam logic signed [19:0] ANG_LIMIT = 20'sd23040;

  // CORDIC gain compensation, 0.60725293500888 in Q1.30.
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  // round(atan(2^-i) * 180/pi * 2^20)
  localparam logic signed [Z_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
    29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
    29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
    29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
    29'sd917,      29'sd458,      29'sd229,      29'sd115,
    29'sd57,       29'sd29,       29'sd14,       29'sd7
  };

  // Payload carried through the rotation stages.
  typedef struct packed {
    logic                   func;
    logic                   zero;
    logic signed [15:0]     base;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } prc_stage_t;

  // Saturate to +-lim and narrow to the 17-bit result width.
  function automatic logic signed [16:0] sat_res(input logic signed [19:0] v,
                                                 input logic signed [19:0] lim);
    logic signed [19:0] c;
    begin
      if (v > lim) begin
        c = lim;
      end else if (v < -lim) begin
        c = -lim;
      end else begin
        c = v;
      end
      return c[16:0];
    end
  endfunction

endpackage

[hw/rtl/prc_if.sv]
// ----------------------------------------------------------------------------
// prc_if
// Request and response channels of the polar/rectangular converter.
// ----------------------------------------------------------------------------
interface prc_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] first_operand;
  logic signed [15:0] second_operand;

  modport source (output valid, output func, output first_operand,
                  output second_operand, input ready);
  modport sink (input valid, input func, input first_operand,
                input second_operand, output ready);
endinterface

interface prc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] first_result;
  logic signed [16:0] second_result;

  modport source (output valid, output first_result, output second_result,
                  input ready);
  modport sink (input valid, input first_result, input second_result,
                output ready);
endinterface

[hw/rtl/polar_rectangular_converter.sv]
// ----------------------------------------------------------------------------
// polar_rectangular_converter
// Pipelined CORDIC converter between polar and rectangular Q8.8 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request per valid/ready handshake: func selects
//   polar to rectangular (modulus, angle in 1/128 degree) or rectangular to
//   polar (abscissa, ordinate). out_rsp returns exactly one result per
//   request, in request order.
//   From acceptance to out_rsp.valid an item passes one entry stage for
//   angle reduction, one stage per micro-rotation, one for the gain
//   multiply and one for round/saturate.
//   Throughput is one request per cycle while out_rsp.ready is high; every
//   stage holds its own valid bit and takes a new item whenever it is empty
//   or its successor moves. When the receiver holds out_rsp.ready low,
//   results back up stage by stage; in_req.ready drops only once every stage
//   is occupied, and no request is lost or repeated.
//   Synchronous reset empties the pipeline; the block keeps no other state.
//   CORDIC_STAGES ranges from 8 to 24.
// ----------------------------------------------------------------------------
module polar_rectangular_converter
  import prc_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  prc_req_if.sink   in_req,
  prc_rsp_if.source out_rsp
);

  logic [CORDIC_STAGES:0] chain_valid;
  logic [CORDIC_STAGES:0] chain_ready;
  prc_stage_t             chain_data [CORDIC_STAGES+1];

  prc_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_req),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    prc_cordic_stage #(
      .STAGE (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  prc_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (chain_valid[CORDIC_STAGES]),
    .ready_o (chain_ready[CORDIC_STAGES]),
    .data_i  (chain_data[CORDIC_STAGES]),
    .rsp     (out_rsp)
  );

endmodule

[hw/rtl/prc_prep.sv]
// ----------------------------------------------------------------------------
// prc_prep
// Entry stage: angle reduction and quadrant folding, operand widening.
// ----------------------------------------------------------------------------
module prc_prep
  import prc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  prc_req_if.sink    req,
  output logic       valid_o,
  input  logic       ready_i,
  output prc_stage_t data_o
);

  logic               valid_r;
  prc_stage_t         data_r;
  prc_stage_t         data_nxt;
  logic               adv;

  logic signed [16:0] a_ext;
  logic signed [16:0] b_ext;
  logic signed [16:0] ang_red;
  logic signed [16:0] ang_fold;
  logic signed [16:0] x_op;
  logic signed [16:0] y_op;
  logic signed [15:0] base;
  logic               neg;

  assign adv       = !valid_r || ready_i;
  assign req.ready = adv;
  assign valid_o   = valid_r;
  assign data_o    = data_r;

  assign a_ext = {req.first_operand[15], req.first_operand};
  assign b_ext = {req.second_operand[15], req.second_operand};

  always_comb begin
    // Reduce into -180..+180 degrees.
    if (b_ext < -HALF_TURN) begin
      ang_red = b_ext + FULL_TURN;
    end else if (b_ext >= HALF_TURN) begin
      ang_red = b_ext - FULL_TURN;
    end else begin
      ang_red = b_ext;
    end

    neg  = 1'b0;
    base = '0;
    if (req.func == FUNC_P2R) begin
      // Fold the back half plane onto the front one with the modulus negated.
      if (ang_red > QUARTER_TURN) begin
        ang_fold = ang_red - HALF_TURN;
        neg      = 1'b1;
      end else if (ang_red < -QUARTER_TURN) begin
        ang_fold = ang_red + HALF_TURN;
        neg      = 1'b1;
      end else begin
        ang_fold = ang_red;
      end
      x_op = neg ? -a_ext : a_ext;
      y_op = '0;
    end else begin
      ang_fold = '0;
      neg      = a_ext[16];
      if (neg) begin
        base = b_ext[16] ? -HALF_TURN[15:0] : HALF_TURN[15:0];
      end
      x_op = neg ? -a_ext : a_ext;
      y_op = neg ? -b_ext : b_ext;
    end

    data_nxt.func = req.func;
    data_nxt.zero = (req.func == FUNC_R2P) && (a_ext == '0) && (b_ext == '0);
    data_nxt.base = base;
    data_nxt.x    = {{(XY_W-17){x_op[16]}}, x_op} <<< GUARD_BITS;
    data_nxt.y    = {{(XY_W-17){y_op[16]}}, y_op} <<< GUARD_BITS;
    data_nxt.z    = {{(Z_W-17){ang_fold[16]}}, ang_fold} <<< ANG_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req.valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

[hw/rtl/prc_cordic_stage.sv]
// ----------------------------------------------------------------------------
// prc_cordic_stage
// One registered CORDIC micro-rotation, rotation or vectoring per item.
// ----------------------------------------------------------------------------
module prc_cordic_stage
  import prc_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  output logic       ready_o,
  input  prc_stage_t data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output prc_stage_t data_o
);

  logic                   valid_r;
  prc_stage_t             data_r;
  prc_stage_t             data_nxt;
  logic                   adv;
  logic                   up;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign adv     = !valid_r || ready_i;
  assign ready_o = adv;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  assign up = (data_i.func == FUNC_R2P) ? data_i.y[XY_W-1] : !data_i.z[Z_W-1];
  assign dx = data_i.y >>> STAGE;
  assign dy = data_i.x >>> STAGE;

  always_comb begin
    data_nxt = data_i;
    if (up) begin
      data_nxt.x = data_i.x - dx;
      data_nxt.y = data_i.y + dy;
      data_nxt.z = data_i.z - ATAN_TABLE[STAGE];
    end else begin
      data_nxt.x = data_i.x + dx;
      data_nxt.y = data_i.y - dy;
      data_nxt.z = data_i.z + ATAN_TABLE[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

[hw/rtl/prc_post.sv]
// ----------------------------------------------------------------------------
// prc_post
// Gain compensation, rounding and saturation in two register stages.
// ----------------------------------------------------------------------------
module prc_post
  import prc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  output logic       ready_o,
  input  prc_stage_t data_i,
  prc_rsp_if.source  rsp
);

  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (GUARD_BITS + 30 - 1);

  // Multiply stage.
  logic                   mul_valid_r;
  logic                   mul_adv;
  logic signed [46:0]     xh_prod_r;
  logic signed [48:0]     xl_prod_r;
  logic signed [46:0]     yh_prod_r;
  logic signed [48:0]     yl_prod_r;
  logic                   func_r;
  logic                   zero_r;
  logic signed [15:0]     base_r;
  logic signed [Z_W-1:0]  z_r;
  logic signed [17:0]     xl;
  logic signed [17:0]     yl;

  // Output stage.
  logic                   out_valid_r;
  logic                   out_adv;
  logic signed [16:0]     first_r;
  logic signed [16:0]     second_r;
  logic signed [16:0]     first_nxt;
  logic signed [16:0]     second_nxt;
  logic signed [63:0]     x_sum;
  logic signed [63:0]     y_sum;
  logic signed [Z_W-1:0]  z_rnd;
  logic signed [19:0]     ang_sum;

  assign mul_adv = !mul_valid_r || out_adv;
  assign out_adv = !out_valid_r || rsp.ready;
  assign ready_o = mul_adv;

  // Split each operand into a signed high part and an unsigned low part.
  assign xl = {1'b0, data_i.x[16:0]};
  assign yl = {1'b0, data_i.y[16:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (mul_adv) begin
      mul_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_adv && valid_i) begin
      xh_prod_r <= $signed(data_i.x[XY_W-1:17]) * GAIN_Q30;
      xl_prod_r <= xl * GAIN_Q30;
      yh_prod_r <= $signed(data_i.y[XY_W-1:17]) * GAIN_Q30;
      yl_prod_r <= yl * GAIN_Q30;
      func_r    <= data_i.func;
      zero_r    <= data_i.zero;
      base_r    <= data_i.base;
      z_r       <= data_i.z;
    end
  end

  always_comb begin
    x_sum = ({{17{xh_prod_r[46]}}, xh_prod_r} <<< 17)
            + {{15{xl_prod_r[48]}}, xl_prod_r} + ROUND_HALF;
    y_sum = ({{17{yh_prod_r[46]}}, yh_prod_r} <<< 17)
            + {{15{yl_prod_r[48]}}, yl_prod_r} + ROUND_HALF;
    z_rnd = z_r + (Z_W'(1) <<< (ANG_SHIFT - 1));
    ang_sum = {{4{base_r[15]}}, base_r}
              + {{4{z_rnd[Z_W-1]}}, z_rnd[ANG_SHIFT+15:ANG_SHIFT]};

    if (zero_r) begin
      first_nxt  = '0;
      second_nxt = '0;
    end else begin
      first_nxt = sat_res(x_sum[63:44], RES_LIMIT);
      if (func_r == FUNC_P2R) begin
        second_nxt = sat_res(y_sum[63:44], RES_LIMIT);
      end else begin
        second_nxt = sat_res(ang_sum, ANG_LIMIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mul_valid_r) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  assign rsp.valid         = out_valid_r;
  assign rsp.first_result  = first_r;
  assign rsp.second_result = second_r;

endmodule
